/* rtl/rau_pkg.sv */
// Package for the rational arithmetic unit: codes, constants and the sequencer state type.
`default_nettype none
package rau_pkg;
   localparam int unsigned WIDTH_DEFAULT = 32;
   localparam int unsigned FIELD_W = 32;

   typedef enum logic [2:0] {
      MODE_ADD = 3'd0,
      MODE_SUB = 3'd1,
      MODE_MUL = 3'd2,
      MODE_DIV = 3'd3,
      MODE_NEG = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_OVF  = 2'd1,
      STATUS_ZDEN = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_COMBINE,
      ST_GCD_SETUP,
      ST_MOD,
      ST_GCD_NEXT,
      ST_DIV,
      ST_DIV_NEXT,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

/* rtl/rational_arithmetic_unit.sv */
// Rational arithmetic unit: sign-magnitude fraction add, subtract, multiply, divide, negate.
// One item at a time. An item's fractions are multiplied out with one shared multiplier
// (three products, one per cycle), combined, then reduced with a Euclidean GCD whose
// remainders come from one shared restoring divider that retires one quotient bit a
// cycle. The GCD takes up to about 1.44*WIDTH remainder steps, and two final divisions
// then divide the numerator and the denominator by the GCD. Negate skips the multiplier
// and the reduction; a zero numerator or denominator skips the reduction. req_stall is
// high from acceptance until the result item is taken from the output register. Results
// wrap at WIDTH bits with status 1; a zero unreduced denominator gives 0/0 with status 2.
`default_nettype none
module rational_arithmetic_unit #(
   parameter int unsigned WIDTH = rau_pkg::WIDTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [2:0]                 req_mode,
   input  wire logic                       req_lhs_sign,
   input  wire logic [rau_pkg::FIELD_W-1:0] req_lhs_numerator,
   input  wire logic [rau_pkg::FIELD_W-1:0] req_lhs_denominator,
   input  wire logic                       req_rhs_sign,
   input  wire logic [rau_pkg::FIELD_W-1:0] req_rhs_numerator,
   input  wire logic [rau_pkg::FIELD_W-1:0] req_rhs_denominator,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_res_sign,
   output logic [rau_pkg::FIELD_W-1:0]     rsp_res_numerator,
   output logic [rau_pkg::FIELD_W-1:0]     rsp_res_denominator,
   output logic [1:0]                      rsp_status
);
   localparam int unsigned FW  = rau_pkg::FIELD_W;
   localparam int unsigned OPW = (WIDTH < FW) ? WIDTH : FW;   // operand bits used
   localparam int unsigned CW  = $clog2(WIDTH + 1);

   rau_pkg::state_type state_ff, state_in;

   // operands held for the whole item
   logic [2:0]       mode_ff, mode_in;
   logic             ls_ff, ls_in, rs_ff, rs_in;
   logic [OPW-1:0]   ln_ff, ln_in, ld_ff, ld_in, rn_ff, rn_in, rd_ff, rd_in;
   // products: a, b, den
   logic [WIDTH-1:0] pa_ff, pa_in, pb_ff, pb_in, pd_ff, pd_in;
   logic [1:0]       pcnt_ff, pcnt_in;
   logic             ovf_ff, ovf_in;
   logic             sign_ff, sign_in;
   // numerator/denominator and GCD working values
   logic [WIDTH-1:0] num_ff, num_in, den_ff, den_in;
   logic [WIDTH-1:0] ga_ff, ga_in, gb_ff, gb_in;
   logic             dsel_ff, dsel_in;        // which final division runs: 0 num, 1 den
   // shared restoring divider
   logic [WIDTH-1:0] dvd_ff, dvd_in, dvs_ff, dvs_in, rem_ff, rem_in;
   logic [CW-1:0]    dcnt_ff, dcnt_in;
   // output register
   logic             ovalid_ff, ovalid_in;
   logic             osign_ff, osign_in;
   logic [FW-1:0]    onum_ff, onum_in, oden_ff, oden_in;
   logic [1:0]       ostat_ff, ostat_in;

   // shared multiplier, operands chosen by product count
   logic [OPW-1:0]     mx, my;
   logic [2*OPW-1:0]   mprod;
   logic [WIDTH-1:0]   mwrap;
   logic               mover;
   // shared divider step
   logic [WIDTH:0]     rshift;
   logic [WIDTH:0]     rtrial;
   logic               rfit;
   // adder
   logic [WIDTH:0]     asum;

   logic accept;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != rau_pkg::ST_IDLE) || ovalid_ff;

   always_comb begin
      unique case (pcnt_ff)
         2'd0: begin mx = ln_ff; my = (mode_ff == rau_pkg::MODE_MUL) ? rn_ff : rd_ff; end
         2'd1: begin mx = (mode_ff == rau_pkg::MODE_MUL) ? ld_ff : ld_ff;
                     my = (mode_ff == rau_pkg::MODE_MUL) ? rd_ff : rn_ff; end
         default: begin mx = ld_ff; my = rd_ff; end
      endcase
      mprod = {{OPW{1'b0}}, mx} * {{OPW{1'b0}}, my};
      mwrap = WIDTH'({{WIDTH{1'b0}}, mprod});
      mover = ({{WIDTH{1'b0}}, mprod} >> WIDTH) != '0;
      rshift = {rem_ff, dvd_ff[WIDTH-1]};
      rtrial = rshift - {1'b0, dvs_ff};
      rfit   = !rtrial[WIDTH];
      asum   = {1'b0, pa_ff} + {1'b0, pb_ff};
   end

   always_comb begin
      logic es;
      es = 1'b0;
      state_in = state_ff;
      mode_in = mode_ff; ls_in = ls_ff; rs_in = rs_ff;
      ln_in = ln_ff; ld_in = ld_ff; rn_in = rn_ff; rd_in = rd_ff;
      pa_in = pa_ff; pb_in = pb_ff; pd_in = pd_ff; pcnt_in = pcnt_ff;
      ovf_in = ovf_ff; sign_in = sign_ff;
      num_in = num_ff; den_in = den_ff; ga_in = ga_ff; gb_in = gb_ff;
      dsel_in = dsel_ff;
      dvd_in = dvd_ff; dvs_in = dvs_ff; rem_in = rem_ff; dcnt_in = dcnt_ff;
      ovalid_in = ovalid_ff; osign_in = osign_ff; onum_in = onum_ff;
      oden_in = oden_ff; ostat_in = ostat_ff;

      // drop the result once taken
      if (ovalid_ff && !rsp_stall) begin
         ovalid_in = 1'b0;
      end

      unique case (state_ff)
         rau_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in = req_mode; ls_in = req_lhs_sign; rs_in = req_rhs_sign;
               ln_in = OPW'(req_lhs_numerator); ld_in = OPW'(req_lhs_denominator);
               rn_in = OPW'(req_rhs_numerator); rd_in = OPW'(req_rhs_denominator);
               pcnt_in = 2'd0; ovf_in = 1'b0;
               if (req_mode > rau_pkg::MODE_DIV) begin
                  // negate (and codes 5 to 7) passes the right operand through with its sign inverted
                  ovalid_in = 1'b1;
                  osign_in  = !req_rhs_sign;
                  onum_in   = FW'(OPW'(req_rhs_numerator));
                  oden_in   = FW'(OPW'(req_rhs_denominator));
                  ostat_in  = rau_pkg::STATUS_OK;
               end else begin
                  state_in = rau_pkg::ST_MUL;
               end
            end
         end
         rau_pkg::ST_MUL: begin
            // one product a cycle; the third one counts only for add and subtract
            if (mover && (pcnt_ff != 2'd2 || mode_ff == rau_pkg::MODE_ADD
                          || mode_ff == rau_pkg::MODE_SUB)) ovf_in = 1'b1;
            unique case (pcnt_ff)
               2'd0: pa_in = mwrap;
               2'd1: pb_in = mwrap;
               default: pd_in = mwrap;
            endcase
            pcnt_in = pcnt_ff + 2'd1;
            if (pcnt_ff == 2'd2) state_in = rau_pkg::ST_COMBINE;
         end
         rau_pkg::ST_COMBINE: begin
            den_in = pd_ff;
            if (mode_ff == rau_pkg::MODE_ADD || mode_ff == rau_pkg::MODE_SUB) begin
               es = (mode_ff == rau_pkg::MODE_SUB) ? !rs_ff : rs_ff;
               if (ls_ff == es) begin
                  num_in = asum[WIDTH-1:0];
                  if (asum[WIDTH]) ovf_in = 1'b1;
                  sign_in = ls_ff;
               end else if (pa_ff > pb_ff) begin
                  num_in = pa_ff - pb_ff; sign_in = ls_ff;
               end else begin
                  num_in = pb_ff - pa_ff; sign_in = es;
               end
            end else begin
               // multiply uses (a, den) = (ln*rn, ld*rd); divide uses (a, b) = (ln*rd, ld*rn)
               num_in  = pa_ff;
               den_in  = (mode_ff == rau_pkg::MODE_MUL) ? pd_ff : pb_ff;
               sign_in = ls_ff ^ rs_ff;
            end
            state_in = rau_pkg::ST_GCD_SETUP;
         end
         rau_pkg::ST_GCD_SETUP: begin
            if (den_ff == '0) begin
               ovalid_in = 1'b1; osign_in = 1'b0; onum_in = '0; oden_in = '0;
               ostat_in = rau_pkg::STATUS_ZDEN;
               state_in = rau_pkg::ST_IDLE;
            end else if (num_ff == '0) begin
               ovalid_in = 1'b1; osign_in = 1'b0; onum_in = '0; oden_in = FW'(1);
               ostat_in = ovf_ff ? rau_pkg::STATUS_OVF : rau_pkg::STATUS_OK;
               state_in = rau_pkg::ST_IDLE;
            end else begin
               ga_in = num_ff; gb_in = den_ff;
               dvd_in = den_ff; dvs_in = num_ff; rem_in = '0;
               dcnt_in = CW'(WIDTH);
               state_in = rau_pkg::ST_MOD;
            end
         end
         rau_pkg::ST_MOD, rau_pkg::ST_DIV: begin
            // one quotient bit a cycle; quotient shifts into dvd
            rem_in  = rfit ? rtrial[WIDTH-1:0] : rshift[WIDTH-1:0];
            dvd_in  = {dvd_ff[WIDTH-2:0], rfit};
            dcnt_in = dcnt_ff - CW'(1);
            if (dcnt_ff == CW'(1)) begin
               state_in = (state_ff == rau_pkg::ST_MOD) ? rau_pkg::ST_GCD_NEXT
                                                        : rau_pkg::ST_DIV_NEXT;
            end
         end
         rau_pkg::ST_GCD_NEXT: begin
            // b = a, a = b mod a
            if (rem_ff == '0) begin
               gb_in = ga_ff;
               dvd_in = num_ff; dvs_in = ga_ff; rem_in = '0;
               dcnt_in = CW'(WIDTH); dsel_in = 1'b0;
               state_in = rau_pkg::ST_DIV;
            end else begin
               gb_in = ga_ff; ga_in = rem_ff;
               dvd_in = ga_ff; dvs_in = rem_ff; rem_in = '0;
               dcnt_in = CW'(WIDTH);
               state_in = rau_pkg::ST_MOD;
            end
         end
         rau_pkg::ST_DIV_NEXT: begin
            if (!dsel_ff) begin
               num_in = dvd_ff;
               dvd_in = den_ff; dvs_in = gb_ff; rem_in = '0;
               dcnt_in = CW'(WIDTH); dsel_in = 1'b1;
               state_in = rau_pkg::ST_DIV;
            end else begin
               den_in = dvd_ff;
               state_in = rau_pkg::ST_DONE;
            end
         end
         rau_pkg::ST_DONE: begin
            ovalid_in = 1'b1;
            osign_in  = sign_ff;
            onum_in   = FW'({{FW{1'b0}}, num_ff});
            oden_in   = FW'({{FW{1'b0}}, den_ff});
            ostat_in  = ovf_ff ? rau_pkg::STATUS_OVF : rau_pkg::STATUS_OK;
            state_in  = rau_pkg::ST_IDLE;
         end
         default: state_in = rau_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rau_pkg::ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in; ls_ff <= ls_in; rs_ff <= rs_in;
      ln_ff <= ln_in; ld_ff <= ld_in; rn_ff <= rn_in; rd_ff <= rd_in;
      pa_ff <= pa_in; pb_ff <= pb_in; pd_ff <= pd_in; pcnt_ff <= pcnt_in;
      ovf_ff <= ovf_in; sign_ff <= sign_in;
      num_ff <= num_in; den_ff <= den_in; ga_ff <= ga_in; gb_ff <= gb_in;
      dsel_ff <= dsel_in;
      dvd_ff <= dvd_in; dvs_ff <= dvs_in; rem_ff <= rem_in; dcnt_ff <= dcnt_in;
      osign_ff <= osign_in; onum_ff <= onum_in; oden_ff <= oden_in; ostat_ff <= ostat_in;
   end

   assign rsp_valid           = ovalid_ff;
   assign rsp_res_sign        = osign_ff;
   assign rsp_res_numerator   = onum_ff;
   assign rsp_res_denominator = oden_ff;
   assign rsp_status          = ostat_ff;

   // a stalled result holds
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res_numerator)
         && $stable(rsp_status))
      else $error("result changed under stall");
   // zero-denominator results are 0/0
   a_zden: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rau_pkg::STATUS_ZDEN |->
         rsp_res_numerator == '0 && rsp_res_denominator == '0)
      else $error("zero denominator result not cleared");
   // no input accepted while an item is in work
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != rau_pkg::ST_IDLE |-> req_stall)
      else $error("ready while busy");
   // the divisor of a remainder step is never zero
   a_dvs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rau_pkg::ST_MOD || state_ff == rau_pkg::ST_DIV) |-> dvs_ff != '0)
      else $error("division by zero in reduction");
endmodule
`default_nettype wire

/* tb/rational_arithmetic_unit_test.sv */
// Testbench for the rational arithmetic unit: random and directed fraction items, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none

class fraction_scoreboard;
   typedef struct packed {
      logic        sign;
      logic [31:0] numerator;
      logic [31:0] denominator;
      logic [1:0]  status;
   } fraction_result_type;

   fraction_result_type pending_results[$];
   int unsigned    error_count;
   int unsigned    checked_count;

   // Euclid on 64-bit values, as the block reduces fractions.
   function automatic logic [63:0] common_divisor(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (a != 0) begin
         t = b % a;
         b = a;
         a = t;
      end
      return b;
   endfunction

   // Compute the expected result of one accepted item and queue it.
   function void note_item(logic [2:0] mode, logic ls, logic [31:0] ln, logic [31:0] ld,
                           logic rs, logic [31:0] rn, logic [31:0] rd);
      fraction_result_type r;
      logic [63:0] a, b, num, den, g;
      logic        es, sign, ovf;
      ovf = 1'b0;
      sign = 1'b0;
      if (mode > rau_pkg::MODE_DIV) begin
         r.sign = ~rs;
         r.numerator = rn;
         r.denominator = rd;
         r.status = rau_pkg::STATUS_OK;
         pending_results.push_back(r);
         return;
      end
      if (mode == rau_pkg::MODE_ADD || mode == rau_pkg::MODE_SUB) begin
         a = 64'(ln) * 64'(rd);
         b = 64'(rn) * 64'(ld);
         if (a[63:32] != 0) ovf = 1'b1;
         if (b[63:32] != 0) ovf = 1'b1;
         a = {32'd0, a[31:0]};
         b = {32'd0, b[31:0]};
         es = (mode == rau_pkg::MODE_SUB) ? ~rs : rs;
         if (ls == es) begin
            num = a + b;
            if (num[32]) ovf = 1'b1;
            num = {32'd0, num[31:0]};
            sign = ls;
         end else if (a > b) begin
            num = a - b;
            sign = ls;
         end else begin
            num = b - a;
            sign = es;
         end
         den = 64'(ld) * 64'(rd);
      end else if (mode == rau_pkg::MODE_MUL) begin
         num = 64'(ln) * 64'(rn);
         den = 64'(ld) * 64'(rd);
         if (num[63:32] != 0) ovf = 1'b1;
         sign = ls ^ rs;
      end else begin
         num = 64'(ln) * 64'(rd);
         den = 64'(ld) * 64'(rn);
         if (num[63:32] != 0) ovf = 1'b1;
         sign = ls ^ rs;
      end
      if (den[63:32] != 0) ovf = 1'b1;
      num = {32'd0, num[31:0]};
      den = {32'd0, den[31:0]};
      if (den == 0) begin
         r = '{1'b0, 32'd0, 32'd0, rau_pkg::STATUS_ZDEN};
      end else begin
         g = common_divisor(num, den);
         num = num / g;
         den = den / g;
         if (num == 0) sign = 1'b0;
         r.sign = sign;
         r.numerator = num[31:0];
         r.denominator = den[31:0];
         r.status = ovf ? rau_pkg::STATUS_OVF : rau_pkg::STATUS_OK;
      end
      pending_results.push_back(r);
   endfunction

   // Compare one accepted result with the oldest expectation.
   function void check_result(logic sign, logic [31:0] num, logic [31:0] den,
                              logic [1:0] status);
      fraction_result_type e;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result %b %h/%h status %0d", $time, sign, num, den, status);
         error_count++;
         return;
      end
      e = pending_results.pop_front();
      checked_count++;
      if (e.sign !== sign)
         $display("%0t: sign expected %b actual %b", $time, e.sign, sign);
      if (e.numerator !== num)
         $display("%0t: numerator expected %h actual %h", $time, e.numerator, num);
      if (e.denominator !== den)
         $display("%0t: denominator expected %h actual %h", $time, e.denominator, den);
      if (e.status !== status)
         $display("%0t: status expected %0d actual %0d", $time, e.status, status);
      if (e.sign !== sign || e.numerator !== num || e.denominator !== den
          || e.status !== status)
         error_count++;
   endfunction
endclass

module rational_arithmetic_unit_test;
   localparam int unsigned RANDOM_ITEMS = 1430;
   localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = 3'd0;
   logic        req_lhs_sign = 1'b0;
   logic [31:0] req_lhs_numerator = '0;
   logic [31:0] req_lhs_denominator = '0;
   logic        req_rhs_sign = 1'b0;
   logic [31:0] req_rhs_numerator = '0;
   logic [31:0] req_rhs_denominator = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic        rsp_res_sign;
   logic [31:0] rsp_res_numerator;
   logic [31:0] rsp_res_denominator;
   logic [1:0]  rsp_status;

   fraction_scoreboard fraction_board = new();
   longint unsigned    cycle_count = 0;
   bit                 hold_off_rsp = 1'b0;
   int unsigned        mode_seen[8];

   rational_arithmetic_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_mode),
      .req_lhs_sign(req_lhs_sign), .req_lhs_numerator(req_lhs_numerator),
      .req_lhs_denominator(req_lhs_denominator),
      .req_rhs_sign(req_rhs_sign), .req_rhs_numerator(req_rhs_numerator),
      .req_rhs_denominator(req_rhs_denominator),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_res_sign(rsp_res_sign), .rsp_res_numerator(rsp_res_numerator),
      .rsp_res_denominator(rsp_res_denominator), .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // Count cycles and abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Sample both handshakes at the rising edge; note accepted items, check results.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         fraction_board.note_item(req_mode, req_lhs_sign, req_lhs_numerator,
                                  req_lhs_denominator, req_rhs_sign, req_rhs_numerator,
                                  req_rhs_denominator);
         mode_seen[req_mode]++;
      end
      if (!reset && rsp_valid && !rsp_stall)
         fraction_board.check_result(rsp_res_sign, rsp_res_numerator, rsp_res_denominator,
                                     rsp_status);
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned gap_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return 0;
      if (pick < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 80);
   endfunction

   // Receiver: drive stall at the falling edge with random gaps; honor long hold-offs.
   initial begin : receiver
      int unsigned run_len;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_rsp) begin
            rsp_stall <= 1'b1;
            // Hold off for a long stretch counted here while the sender keeps offering.
            repeat (3000) @(negedge clock);
            hold_off_rsp = 1'b0;
         end else if ($urandom_range(0, 9) < 7) begin
            rsp_stall <= 1'b0;
            run_len = $urandom_range(1, 20);
            repeat (run_len) @(negedge clock);
         end else begin
            rsp_stall <= 1'b1;
            run_len = gap_length() + 1;
            repeat (run_len) @(negedge clock);
         end
      end
   end

   // Offer one item at the falling edge and hold it until accepted.
   task automatic send_item(input logic [2:0] mode, input logic ls, input logic [31:0] ln,
                            input logic [31:0] ld, input logic rs, input logic [31:0] rn,
                            input logic [31:0] rd);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_lhs_sign <= ls;
      req_lhs_numerator <= ln;
      req_lhs_denominator <= ld;
      req_rhs_sign <= rs;
      req_rhs_numerator <= rn;
      req_rhs_denominator <= rd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid for a random gap (none when zero).
   task automatic idle_sender(input int unsigned cycles);
      if (cycles == 0) return;
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Operand magnitude: small values dominate so reductions stay common and quick.
   function automatic logic [31:0] pick_magnitude();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) return 32'd0;
      if (pick < 14) return 32'hFFFF_FFFF;
      if (pick < 60) return $urandom_range(1, 30);
      if (pick < 80) return $urandom_range(1, 65535);
      return $urandom;
   endfunction

   function automatic logic [2:0] pick_mode();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 92) return 3'($urandom_range(rau_pkg::MODE_ADD, rau_pkg::MODE_DIV));
      if (pick < 97) return rau_pkg::MODE_NEG;
      return 3'($urandom_range(5, 7));
   endfunction

   initial begin : sender
      int unsigned i;
      logic [31:0] factor;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, every mode, zero denominators, cancellation, wraps.
      send_item(rau_pkg::MODE_ADD, 1'b0, 32'd1, 32'd2, 1'b0, 32'd1, 32'd3);
      send_item(rau_pkg::MODE_SUB, 1'b1, 32'd3, 32'd4, 1'b1, 32'd3, 32'd4);
      send_item(rau_pkg::MODE_SUB, 1'b0, 32'd1, 32'd3, 1'b0, 32'd1, 32'd2);
      send_item(rau_pkg::MODE_ADD, 1'b1, 32'd5, 32'd6, 1'b0, 32'd1, 32'd6);
      send_item(rau_pkg::MODE_MUL, 1'b1, 32'd6, 32'd4, 1'b0, 32'd2, 32'd9);
      send_item(rau_pkg::MODE_DIV, 1'b1, 32'd3, 32'd7, 1'b1, 32'd9, 32'd14);
      send_item(rau_pkg::MODE_DIV, 1'b0, 32'd3, 32'd7, 1'b0, 32'd0, 32'd5);
      send_item(rau_pkg::MODE_ADD, 1'b0, 32'd1, 32'd0, 1'b0, 32'd1, 32'd1);
      send_item(rau_pkg::MODE_MUL, 1'b1, 32'd0, 32'd5, 1'b0, 32'd7, 32'd3);
      send_item(rau_pkg::MODE_NEG, 1'b0, 32'd9, 32'd9, 1'b0, 32'd0, 32'd0);
      send_item(rau_pkg::MODE_NEG, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
      send_item(3'd5, 1'b0, 32'd1, 32'd1, 1'b0, 32'd4, 32'd6);
      send_item(3'd6, 1'b1, 32'd1, 32'd1, 1'b1, 32'd8, 32'd0);
      send_item(3'd7, 1'b0, 32'd1, 32'd1, 1'b0, 32'hFFFF_FFFF, 32'd3);
      send_item(rau_pkg::MODE_MUL, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
      send_item(rau_pkg::MODE_ADD, 1'b0, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'hFFFF_FFFF, 32'd1);
      send_item(rau_pkg::MODE_MUL, 1'b0, 32'd1, 32'h0001_0000, 1'b0, 32'd1, 32'h0001_0000);
      send_item(rau_pkg::MODE_SUB, 1'b1, 32'hFFFF_FFFF, 32'd1, 1'b0, 32'd0, 32'd1);
      send_item(rau_pkg::MODE_DIV, 1'b1, 32'd0, 32'd1, 1'b1, 32'd5, 32'd1);
      send_item(rau_pkg::MODE_ADD, 1'b1, 32'd0, 32'd1, 1'b1, 32'd0, 32'd1);

      // Pause until every expected result has come back.
      req_valid <= 1'b0;
      while (fraction_board.pending_results.size() != 0) @(negedge clock);

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         // Once, make the receiver hold off while items keep coming.
         if (i == 200) hold_off_rsp = 1'b1;
         if (i == 700) begin
            req_valid <= 1'b0;
            while (fraction_board.pending_results.size() != 0) @(negedge clock);
         end
         if (i % 5 == 0) begin
            // Share a factor so the divisor loop does real reductions.
            factor = $urandom_range(2, 1000);
            send_item(pick_mode(), 1'($urandom), factor * $urandom_range(1, 500),
                      factor * $urandom_range(1, 500), 1'($urandom),
                      factor * $urandom_range(1, 500), factor * $urandom_range(1, 500));
         end else begin
            send_item(pick_mode(), 1'($urandom), pick_magnitude(), pick_magnitude(),
                      1'($urandom), pick_magnitude(), pick_magnitude());
         end
         idle_sender(gap_length());
      end
      req_valid <= 1'b0;

      while (fraction_board.pending_results.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);

      $display("ran %0d items, checked %0d results", RANDOM_ITEMS + 20,
               fraction_board.checked_count);
      $display("modes add %0d sub %0d mul %0d div %0d neg %0d, spare codes %0d",
               mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4],
               mode_seen[5] + mode_seen[6] + mode_seen[7]);
      if (fraction_board.error_count == 0 && fraction_board.pending_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

`default_nettype wire

/* rational_arithmetic_unit.f */
rtl/rau_pkg.sv
rtl/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_test.sv
